### sv/lant_pkg.sv
// Shared types and constants for the Langton's ant stepper.
// No dependencies; imported by every module of the block.
package lant_pkg;

  localparam int DEF_MAX_WIDTH   = 64;
  localparam int DEF_MAX_HEIGHT  = 64;
  localparam int POS_LIMIT       = 64;
  localparam int RST_GRID_WIDTH  = 64;
  localparam int RST_GRID_HEIGHT = 32;

  localparam int POS_W      = 6;
  localparam int SIZE_W     = 7;
  localparam int AGE_W      = 8;
  localparam int DIR_W      = 2;
  localparam int CMD_W      = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [AGE_W-1:0] AGE_LIMIT = 8'd255;

  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef struct packed {
    logic rd_pos;
    logic rd_cell;
    logic restart;
    logic clr_start;
    logic clr_run;
    logic reduce;
    logic commit;
    logic emit_read;
    logic emit_plain;
  } lant_ctrl_t;

  typedef struct packed {
    logic pos_in_grid;
    logic clr_last;
    logic out_free;
  } lant_stat_t;

endpackage

### sv/lant_cfg.sv
// APB register file for grid width and height, with size clamping.
// Depends on lant_pkg.
module lant_cfg #(
  parameter int MAX_WIDTH  = lant_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lant_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lant_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lant_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lant_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [lant_pkg::SIZE_W-1:0]     eff_w_o,
  output logic [lant_pkg::SIZE_W-1:0]     eff_h_o
);
  import lant_pkg::*;

  localparam int LimW = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;
  localparam int LimH = (MAX_HEIGHT < POS_LIMIT) ? MAX_HEIGHT : POS_LIMIT;

  logic [SIZE_W-1:0] width_q, width_d;
  logic [SIZE_W-1:0] height_q, height_d;
  logic              wr_en;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    r = v;
    if (r == '0) r = SIZE_W'(1);
    if (r > lim) r = lim;
    return r;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_GRID_WIDTH:  width_d  = pwdata[SIZE_W-1:0];
        REG_GRID_HEIGHT: height_d = pwdata[SIZE_W-1:0];
        default:         width_d  = width_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_WIDTH:  prdata = CFG_DATA_W'(width_q);
      REG_GRID_HEIGHT: prdata = CFG_DATA_W'(height_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(RST_GRID_WIDTH);
      height_q <= SIZE_W'(RST_GRID_HEIGHT);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign eff_w_o = clamp_size(width_q, SIZE_W'(LimW));
  assign eff_h_o = clamp_size(height_q, SIZE_W'(LimH));

endmodule

### sv/lant_ctrl.sv
// Command sequencer: accepts commands and drives the datapath.
// Depends on lant_pkg.
module lant_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [lant_pkg::CMD_W-1:0] cmd_i,
  input  lant_pkg::lant_stat_t       stat_i,
  output logic                       in_stall_o,
  output lant_pkg::lant_ctrl_t       ctrl_o
);
  import lant_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_STEP,
    S_READ,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    pend_d  = pend_q;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.clr_run = 1'b1;
        if (stat_i.clr_last) begin
          state_d = pend_q ? S_FIN : S_IDLE;
          pend_d  = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(cmd_i))
            CMD_STEP: begin
              if (stat_i.pos_in_grid) begin
                ctrl_o.rd_pos = 1'b1;
                state_d       = S_STEP;
              end else begin
                state_d = S_REDUCE;
              end
            end
            CMD_READ: begin
              ctrl_o.rd_cell = 1'b1;
              state_d        = S_READ;
            end
            CMD_RESTART: begin
              ctrl_o.restart   = 1'b1;
              ctrl_o.clr_start = 1'b1;
              pend_d           = 1'b1;
              state_d          = S_CLEAR;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_REDUCE: begin
        if (stat_i.pos_in_grid) begin
          ctrl_o.rd_pos = 1'b1;
          state_d       = S_STEP;
        end else begin
          ctrl_o.reduce = 1'b1;
        end
      end
      S_STEP: begin
        if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_READ: begin
        if (stat_i.out_free) begin
          ctrl_o.emit_read = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          ctrl_o.emit_plain = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule

### sv/lant_dp.sv
// Datapath: cell memory, ant position and heading, clear sweep, result register.
// Depends on lant_pkg; driven by lant_ctrl.
module lant_dp #(
  parameter int MAX_WIDTH  = lant_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lant_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lant_pkg::lant_ctrl_t        ctrl_i,
  output lant_pkg::lant_stat_t        stat_o,
  input  logic [lant_pkg::POS_W-1:0]  cell_x_i,
  input  logic [lant_pkg::POS_W-1:0]  cell_y_i,
  input  logic [lant_pkg::DIR_W-1:0]  start_dir_i,
  input  logic [lant_pkg::SIZE_W-1:0] eff_w_i,
  input  logic [lant_pkg::SIZE_W-1:0] eff_h_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [lant_pkg::POS_W-1:0]  ant_x_o,
  output logic [lant_pkg::POS_W-1:0]  ant_y_o,
  output logic [lant_pkg::DIR_W-1:0]  ant_heading_o,
  output logic                        cell_set_o,
  output logic [lant_pkg::AGE_W-1:0]  cell_age_o
);
  import lant_pkg::*;

  localparam int Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW  = $clog2(Depth);
  localparam int SpanW  = $clog2(POS_LIMIT * MAX_WIDTH + POS_LIMIT);
  localparam int CalcW  = (SpanW > AddrW) ? SpanW : AddrW;
  localparam int RstEffW = (RST_GRID_WIDTH < MAX_WIDTH) ?
                           ((RST_GRID_WIDTH < POS_LIMIT) ? RST_GRID_WIDTH : POS_LIMIT) :
                           ((MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT);
  localparam int RstEffH = (RST_GRID_HEIGHT < MAX_HEIGHT) ?
                           ((RST_GRID_HEIGHT < POS_LIMIT) ? RST_GRID_HEIGHT : POS_LIMIT) :
                           ((MAX_HEIGHT < POS_LIMIT) ? MAX_HEIGHT : POS_LIMIT);
  localparam int RstX = RstEffW / 2;
  localparam int RstY = RstEffH / 2;

  logic [AGE_W:0]     cell_mem [Depth];
  logic [AGE_W:0]     rd_data_q;
  logic [AddrW-1:0]   rd_addr_q;
  logic               rd_inrange_q;
  logic [AddrW-1:0]   clr_cnt_q;

  logic [POS_W-1:0]   pos_x_q, pos_y_q;
  logic [DIR_W-1:0]   heading_q;

  logic               out_valid_q;
  logic [POS_W-1:0]   out_x_q, out_y_q;
  logic [DIR_W-1:0]   out_head_q;
  logic               out_set_q;
  logic [AGE_W-1:0]   out_age_q;

  logic               mem_re, mem_we;
  logic [AddrW-1:0]   mem_raddr, mem_waddr;
  logic [AGE_W:0]     mem_wdata;

  logic               cur_col, new_col;
  logic [AGE_W-1:0]   cur_age, new_age;
  logic [DIR_W-1:0]   new_head;
  logic [POS_W-1:0]   last_x, last_y, nx, ny;
  logic               x_in, y_in, cell_in;
  logic               out_free;

  function automatic logic [AddrW-1:0] cell_addr(logic [POS_W-1:0] x,
                                                 logic [POS_W-1:0] y);
    logic [CalcW-1:0] a;
    a = CalcW'(y) * CalcW'(MAX_WIDTH) + CalcW'(x);
    return a[AddrW-1:0];
  endfunction

  assign x_in    = {1'b0, pos_x_q} < eff_w_i;
  assign y_in    = {1'b0, pos_y_q} < eff_h_i;
  assign cell_in = ({1'b0, cell_x_i} < eff_w_i) && ({1'b0, cell_y_i} < eff_h_i);
  assign out_free = !out_valid_q || !out_stall_i;

  assign stat_o.pos_in_grid = x_in && y_in;
  assign stat_o.clr_last    = (clr_cnt_q == AddrW'(Depth - 1));
  assign stat_o.out_free    = out_free;

  assign mem_re    = ctrl_i.rd_pos || ctrl_i.rd_cell;
  assign mem_raddr = ctrl_i.rd_pos ? cell_addr(pos_x_q, pos_y_q)
                                   : cell_addr(cell_x_i, cell_y_i);

  assign cur_col  = rd_data_q[AGE_W];
  assign cur_age  = rd_data_q[AGE_W-1:0];
  assign new_col  = !cur_col;
  assign new_age  = (cur_age == AGE_LIMIT) ? cur_age : cur_age + AGE_W'(1);
  assign new_head = cur_col ? heading_q + DIR_W'(1) : heading_q - DIR_W'(1);
  assign last_x   = POS_W'(eff_w_i - SIZE_W'(1));
  assign last_y   = POS_W'(eff_h_i - SIZE_W'(1));

  always_comb begin
    nx = pos_x_q;
    ny = pos_y_q;
    case (new_head)
      DIR_UP:    ny = (pos_y_q == '0) ? last_y : pos_y_q - POS_W'(1);
      DIR_RIGHT: nx = (pos_x_q == last_x) ? '0 : pos_x_q + POS_W'(1);
      DIR_DOWN:  ny = (pos_y_q == last_y) ? '0 : pos_y_q + POS_W'(1);
      DIR_LEFT:  nx = (pos_x_q == '0) ? last_x : pos_x_q - POS_W'(1);
      default:   nx = pos_x_q;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr_q;
    mem_wdata = {new_col, new_age};
    if (ctrl_i.clr_run) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (ctrl_i.commit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q    <= cell_mem[mem_raddr];
      rd_addr_q    <= mem_raddr;
      rd_inrange_q <= ctrl_i.rd_pos || cell_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      pos_x_q     <= POS_W'(RstX);
      pos_y_q     <= POS_W'(RstY);
      heading_q   <= DIR_UP;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr_start) begin
        clr_cnt_q <= '0;
      end else if (ctrl_i.clr_run) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
      if (ctrl_i.restart) begin
        pos_x_q   <= POS_W'(eff_w_i >> 1);
        pos_y_q   <= POS_W'(eff_h_i >> 1);
        heading_q <= start_dir_i;
      end else if (ctrl_i.reduce) begin
        if (!x_in) pos_x_q <= pos_x_q - POS_W'(eff_w_i);
        if (!y_in) pos_y_q <= pos_y_q - POS_W'(eff_h_i);
      end else if (ctrl_i.commit) begin
        pos_x_q   <= nx;
        pos_y_q   <= ny;
        heading_q <= new_head;
      end
      if (ctrl_i.commit || ctrl_i.emit_read || ctrl_i.emit_plain) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      out_x_q    <= nx;
      out_y_q    <= ny;
      out_head_q <= new_head;
      out_set_q  <= new_col;
      out_age_q  <= new_age;
    end else if (ctrl_i.emit_read || ctrl_i.emit_plain) begin
      out_x_q    <= pos_x_q;
      out_y_q    <= pos_y_q;
      out_head_q <= heading_q;
      out_set_q  <= ctrl_i.emit_read && rd_inrange_q && cur_col;
      out_age_q  <= (ctrl_i.emit_read && rd_inrange_q) ? cur_age : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ant_x_o       = out_x_q;
  assign ant_y_o       = out_y_q;
  assign ant_heading_o = out_head_q;
  assign cell_set_o    = out_set_q;
  assign cell_age_o    = out_age_q;

endmodule

### sv/langtons_ant_stepper_unit.sv
// Langton's ant stepper, top level. Step and read: the cell read is registered, then the
// result register loaded; unused commands load it directly. No new command is taken until
// the last reaches the result register. After the grid shrank, a step first folds the ant
// position into the grid, one wrap at a time. Restart: sweep clears MAX_WIDTH*MAX_HEIGHT
// cells (4096), then the result. A stalled result holds back the next command.
// Reset: same sweep runs with input stalled; config port usable throughout.
module langtons_ant_stepper_unit #(
  parameter int MAX_WIDTH  = lant_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lant_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lant_pkg::CMD_W-1:0]      cmd_i,
  input  logic [lant_pkg::POS_W-1:0]      cell_x_i,
  input  logic [lant_pkg::POS_W-1:0]      cell_y_i,
  input  logic [lant_pkg::DIR_W-1:0]      start_dir_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lant_pkg::POS_W-1:0]      ant_x_o,
  output logic [lant_pkg::POS_W-1:0]      ant_y_o,
  output logic [lant_pkg::DIR_W-1:0]      ant_heading_o,
  output logic                            cell_set_o,
  output logic [lant_pkg::AGE_W-1:0]      cell_age_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lant_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lant_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lant_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lant_pkg::*;

  logic [SIZE_W-1:0] eff_w, eff_h;
  lant_ctrl_t        ctrl;
  lant_stat_t        stat;

  lant_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .eff_w_o(eff_w),
    .eff_h_o(eff_h)
  );

  lant_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .cmd_i     (cmd_i),
    .stat_i    (stat),
    .in_stall_o(in_stall_o),
    .ctrl_o    (ctrl)
  );

  lant_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .start_dir_i  (start_dir_i),
    .eff_w_i      (eff_w),
    .eff_h_i      (eff_h),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .ant_x_o      (ant_x_o),
    .ant_y_o      (ant_y_o),
    .ant_heading_o(ant_heading_o),
    .cell_set_o   (cell_set_o),
    .cell_age_o   (cell_age_o)
  );

endmodule

### sv/lant_checker.sv
// Port-level checks for langtons_ant_stepper_unit, attached by bind.
// Depends on lant_pkg.
module lant_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [lant_pkg::CMD_W-1:0] cmd_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [lant_pkg::POS_W-1:0] ant_x_o,
  input logic [lant_pkg::POS_W-1:0] ant_y_o,
  input logic [lant_pkg::DIR_W-1:0] ant_heading_o,
  input logic                       cell_set_o,
  input logic [lant_pkg::AGE_W-1:0] cell_age_o
);
  import lant_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(ant_x_o) && $stable(ant_y_o) &&
      $stable(ant_heading_o) && $stable(cell_set_o) && $stable(cell_age_o))
    else $error("stalled result changed");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous command in flight");

  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CMD_READ) && !out_valid_o
      |-> ##2 out_valid_o)
    else $error("read result late");

endmodule

bind langtons_ant_stepper_unit lant_checker u_lant_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .cmd_i        (cmd_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .ant_x_o      (ant_x_o),
  .ant_y_o      (ant_y_o),
  .ant_heading_o(ant_heading_o),
  .cell_set_o   (cell_set_o),
  .cell_age_o   (cell_age_o)
);

### sim/tb_langtons_ant_stepper_unit.sv
// Testbench for langtons_ant_stepper_unit: directed table, then random phases per grid size.
// Results are checked against a behavioral ant model kept inside the bench.
// Depends on lant_pkg and the stepper RTL only.
module tb_langtons_ant_stepper_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lant_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int GRID_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [CFG_ADDR_W-1:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [DIR_W-1:0] heading;
    logic             set;
    logic [AGE_W-1:0] age;
  } ant_result_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] cx;
    logic [POS_W-1:0] cy;
    logic [DIR_W-1:0] dir;
    logic             known;
    ant_result_t      res;
  } ant_cmd_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      cmd_i = '0;
  logic [POS_W-1:0]      cell_x_i = '0;
  logic [POS_W-1:0]      cell_y_i = '0;
  logic [DIR_W-1:0]      start_dir_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [POS_W-1:0]      ant_x_o;
  logic [POS_W-1:0]      ant_y_o;
  logic [DIR_W-1:0]      ant_heading_o;
  logic                  cell_set_o;
  logic [AGE_W-1:0]      cell_age_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  langtons_ant_stepper_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .start_dir_i  (start_dir_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ant_x_o      (ant_x_o),
    .ant_y_o      (ant_y_o),
    .ant_heading_o(ant_heading_o),
    .cell_set_o   (cell_set_o),
    .cell_age_o   (cell_age_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Ant model state
  logic [SIZE_W-1:0] grid_w_reg;
  logic [SIZE_W-1:0] grid_h_reg;
  logic [POS_W-1:0]  ant_col;
  logic [POS_W-1:0]  ant_row;
  logic [DIR_W-1:0]  ant_dir;
  bit                cell_colour [GRID_CELLS];
  bit [AGE_W-1:0]    cell_visits [GRID_CELLS];

  ant_result_t pending_results[$];
  int          mismatches = 0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;

  // Grid 64x32 after reset, ant at (32,16) heading up.
  ant_cmd_t directed_rows [20] = '{
    '{CMD_READ,    6'd0,  6'd0,  DIR_UP,    1'b1, '{6'd32, 6'd16, DIR_UP,    1'b0, 8'd0}},
    '{CMD_READ,    6'd63, 6'd63, DIR_LEFT,  1'b1, '{6'd32, 6'd16, DIR_UP,    1'b0, 8'd0}},
    '{CMD_READ,    6'd63, 6'd31, DIR_UP,    1'b1, '{6'd32, 6'd16, DIR_UP,    1'b0, 8'd0}},
    '{CMD_READ,    6'd0,  6'd32, DIR_UP,    1'b1, '{6'd32, 6'd16, DIR_UP,    1'b0, 8'd0}},
    '{CMD_STEP,    6'd0,  6'd0,  DIR_UP,    1'b1, '{6'd31, 6'd16, DIR_LEFT,  1'b1, 8'd1}},
    '{CMD_STEP,    6'd63, 6'd63, DIR_LEFT,  1'b1, '{6'd31, 6'd17, DIR_DOWN,  1'b1, 8'd1}},
    '{CMD_STEP,    6'd21, 6'd42, DIR_RIGHT, 1'b1, '{6'd32, 6'd17, DIR_RIGHT, 1'b1, 8'd1}},
    '{CMD_STEP,    6'd42, 6'd21, DIR_DOWN,  1'b1, '{6'd32, 6'd16, DIR_UP,    1'b1, 8'd1}},
    '{CMD_STEP,    6'd0,  6'd0,  DIR_UP,    1'b1, '{6'd33, 6'd16, DIR_RIGHT, 1'b0, 8'd2}},
    '{CMD_READ,    6'd32, 6'd16, DIR_UP,    1'b1, '{6'd33, 6'd16, DIR_RIGHT, 1'b0, 8'd2}},
    '{CMD_READ,    6'd31, 6'd17, DIR_UP,    1'b1, '{6'd33, 6'd16, DIR_RIGHT, 1'b1, 8'd1}},
    '{CMD_UNUSED,  6'd63, 6'd63, DIR_LEFT,  1'b1, '{6'd33, 6'd16, DIR_RIGHT, 1'b0, 8'd0}},
    '{CMD_STEP,    6'd63, 6'd0,  DIR_LEFT,  1'b0, '0},
    '{CMD_STEP,    6'd0,  6'd63, DIR_DOWN,  1'b0, '0},
    '{CMD_RESTART, 6'd63, 6'd63, DIR_LEFT,  1'b1, '{6'd32, 6'd16, DIR_LEFT,  1'b0, 8'd0}},
    '{CMD_READ,    6'd32, 6'd16, DIR_UP,    1'b1, '{6'd32, 6'd16, DIR_LEFT,  1'b0, 8'd0}},
    '{CMD_STEP,    6'd0,  6'd0,  DIR_UP,    1'b1, '{6'd32, 6'd17, DIR_DOWN,  1'b1, 8'd1}},
    '{CMD_RESTART, 6'd0,  6'd0,  DIR_RIGHT, 1'b1, '{6'd32, 6'd16, DIR_RIGHT, 1'b0, 8'd0}},
    '{CMD_RESTART, 6'd0,  6'd0,  DIR_DOWN,  1'b1, '{6'd32, 6'd16, DIR_DOWN,  1'b0, 8'd0}},
    '{CMD_RESTART, 6'd0,  6'd0,  DIR_UP,    1'b1, '{6'd32, 6'd16, DIR_UP,    1'b0, 8'd0}}
  };

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int used_size(input logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > POS_LIMIT) return POS_LIMIT;
    return v;
  endfunction

  task automatic clear_grid();
    foreach (cell_colour[i]) begin
      cell_colour[i] = 1'b0;
      cell_visits[i] = '0;
    end
  endtask

  task automatic advance_ant(input ant_cmd_t c, output ant_result_t r);
    int w, h, x, y, a;
    w = used_size(grid_w_reg);
    h = used_size(grid_h_reg);
    r = '0;
    case (c.cmd)
      CMD_STEP: begin
        x = ant_col % w;
        y = ant_row % h;
        a = y * DEF_MAX_WIDTH + x;
        if (cell_colour[a]) begin
          ant_dir = ant_dir + 2'd1;
          cell_colour[a] = 1'b0;
        end else begin
          ant_dir = ant_dir + 2'd3;
          cell_colour[a] = 1'b1;
        end
        if (cell_visits[a] != AGE_LIMIT) cell_visits[a] = cell_visits[a] + 1'b1;
        r.set = cell_colour[a];
        r.age = cell_visits[a];
        case (ant_dir)
          DIR_UP:    y = (y == 0) ? h - 1 : y - 1;
          DIR_DOWN:  y = (y + 1 >= h) ? 0 : y + 1;
          DIR_RIGHT: x = (x + 1 >= w) ? 0 : x + 1;
          default:   x = (x == 0) ? w - 1 : x - 1;
        endcase
        ant_col = POS_W'(x);
        ant_row = POS_W'(y);
      end
      CMD_READ: begin
        if (c.cx < w && c.cy < h) begin
          a = c.cy * DEF_MAX_WIDTH + c.cx;
          r.set = cell_colour[a];
          r.age = cell_visits[a];
        end
      end
      CMD_RESTART: begin
        clear_grid();
        ant_col = POS_W'(w / 2);
        ant_row = POS_W'(h / 2);
        ant_dir = c.dir;
      end
      default: ;
    endcase
    r.x = ant_col;
    r.y = ant_row;
    r.heading = ant_dir;
  endtask

  task automatic send_cmd(input ant_cmd_t c);
    int gap;
    ant_result_t r;
    gap = in_quiet ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    cmd_i = c.cmd;
    cell_x_i = c.cx;
    cell_y_i = c.cy;
    start_dir_i = c.dir;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    advance_ant(c, r);
    pending_results.push_back(c.known ? c.res : r);
  endtask

  function automatic ant_cmd_t random_cmd(input bit allow_restart);
    ant_cmd_t c;
    int pick, w, h;
    w = used_size(grid_w_reg);
    h = used_size(grid_h_reg);
    c = '0;
    c.cx = POS_W'($urandom);
    c.cy = POS_W'($urandom);
    c.dir = DIR_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 62) c.cmd = CMD_STEP;
    else if (pick < 92) c.cmd = CMD_READ;
    else if (pick < 96 || !allow_restart) c.cmd = CMD_UNUSED;
    else c.cmd = CMD_RESTART;
    if (c.cmd == CMD_READ && $urandom_range(0, 3) != 0) begin
      c.cx = POS_W'($urandom_range(0, w - 1));
      c.cy = POS_W'($urandom_range(0, h - 1));
    end
    return c;
  endfunction

  task automatic apb_access(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = write;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [SIZE_W-1:0] want);
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b0, addr, '0, rd);
    if (rd[SIZE_W-1:0] !== want)
      flag_mismatch($sformatf("reg @%0d read %0d, want %0d", addr, rd[SIZE_W-1:0], want));
  endtask

  task automatic set_grid(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    logic [CFG_DATA_W-1:0] wd, rd;
    wd = $urandom;
    wd[SIZE_W-1:0] = w;
    apb_access(1'b1, ADDR_GRID_WIDTH, wd, rd);
    grid_w_reg = w;
    wd = $urandom;
    wd[SIZE_W-1:0] = h;
    apb_access(1'b1, ADDR_GRID_HEIGHT, wd, rd);
    grid_h_reg = h;
    check_reg(ADDR_GRID_WIDTH, w);
    check_reg(ADDR_GRID_HEIGHT, h);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side: random stall after every transfer, then compare
  initial begin
    int hold;
    ant_result_t got, want;
    hold = 0;
    forever begin
      @(negedge clk_i);
      out_stall_i = (hold > 0);
      if (hold > 0) hold--;
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
        got = '{ant_x_o, ant_y_o, ant_heading_o, cell_set_o, cell_age_o};
        if (pending_results.size() == 0) begin
          flag_mismatch("result transfer with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (got.x !== want.x)
            flag_mismatch($sformatf("ant_x %0d, want %0d", got.x, want.x));
          if (got.y !== want.y)
            flag_mismatch($sformatf("ant_y %0d, want %0d", got.y, want.y));
          if (got.heading !== want.heading)
            flag_mismatch($sformatf("ant_heading %0d, want %0d", got.heading, want.heading));
          if (got.set !== want.set)
            flag_mismatch($sformatf("cell_set %0d, want %0d", got.set, want.set));
          if (got.age !== want.age)
            flag_mismatch($sformatf("cell_age %0d, want %0d", got.age, want.age));
        end
        hold = out_quiet ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int n_items;
    logic [SIZE_W-1:0] w, h;
    grid_w_reg = SIZE_W'(RST_GRID_WIDTH);
    grid_h_reg = SIZE_W'(RST_GRID_HEIGHT);
    ant_col = POS_W'(RST_GRID_WIDTH / 2);
    ant_row = POS_W'(RST_GRID_HEIGHT / 2);
    ant_dir = DIR_UP;
    clear_grid();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_reg(ADDR_GRID_WIDTH, SIZE_W'(RST_GRID_WIDTH));
    check_reg(ADDR_GRID_HEIGHT, SIZE_W'(RST_GRID_HEIGHT));
    foreach (directed_rows[i]) send_cmd(directed_rows[i]);

    for (int phase = 0; phase < 16; phase++) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      wait_drained();
      case (phase)
        0: begin w = 7'd1;   h = 7'd1;   end
        1: begin w = 7'd0;   h = 7'd0;   end
        2: begin w = 7'd127; h = 7'd127; end
        3: begin w = 7'd64;  h = 7'd64;  end
        4: begin w = 7'd2;   h = 7'd3;   end
        5: begin w = 7'd65;  h = 7'd1;   end
        6: begin w = 7'd1;   h = 7'd64;  end
        7: begin w = 7'd3;   h = 7'd2;   end
        default: begin
          w = SIZE_W'($urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(0, 127));
          h = SIZE_W'($urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(0, 127));
        end
      endcase
      set_grid(w, h);
      // single-cell grid without restarts drives the age into saturation
      n_items = (phase == 0) ? 500 : 56;
      repeat (n_items) send_cmd(random_cmd(phase != 0));
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
sv/lant_pkg.sv
sv/lant_cfg.sv
sv/lant_ctrl.sv
sv/lant_dp.sv
sv/langtons_ant_stepper_unit.sv
sv/lant_checker.sv
sim/tb_langtons_ant_stepper_unit.sv
